[src/chash_pkg.sv]
// Shared definitions for the chained hash table.
// Holds request kinds, status codes and the free-map control and status records.
// No dependencies.
package chash_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  typedef struct packed {
    logic search;
    logic take;
    logic give;
  } fm_ctl_t;

  typedef struct packed {
    logic done;
    logic found;
  } fm_stat_t;

endpackage

[src/chash_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the bucket head slots and the overflow node pool. No dependencies.
module chash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/chash_free_map.sv]
// Free map of the overflow node pool with a word-serial lowest-free search.
// Depends on chash_pkg for the control and status records.
module chash_free_map #(
  parameter int POOL_NODES = 64
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  chash_pkg::fm_ctl_t                          ctl,
  input  logic [(POOL_NODES > 1 ? $clog2(POOL_NODES) : 1)-1:0] take_idx,
  input  logic [(POOL_NODES > 1 ? $clog2(POOL_NODES) : 1)-1:0] give_idx,
  output chash_pkg::fm_stat_t                         stat,
  output logic [(POOL_NODES > 1 ? $clog2(POOL_NODES) : 1)-1:0] found_idx
);
  import chash_pkg::*;

  localparam int NIDX_W = POOL_NODES > 1 ? $clog2(POOL_NODES) : 1;
  localparam int WORDS  = (POOL_NODES + 31) / 32;
  localparam int WD_W   = WORDS > 1 ? $clog2(WORDS) : 1;

  logic [POOL_NODES-1:0] free;
  logic [WORDS*32-1:0]   free_pad;
  logic [WD_W-1:0]       wd;
  logic                  searching;
  logic [31:0]           word;
  logic [4:0]            enc;

  always_comb begin
    free_pad = '0;
    free_pad[POOL_NODES-1:0] = free;
    word = free_pad[wd*32 +: 32];
    enc = '0;
    for (int i = 31; i >= 0; i--) begin
      if (word[i]) begin
        enc = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free      <= '1;
      wd        <= '0;
      searching <= 1'b0;
      stat      <= '0;
      found_idx <= '0;
    end else begin
      if (ctl.take) begin
        free[take_idx] <= 1'b0;
      end
      if (ctl.give) begin
        free[give_idx] <= 1'b1;
      end
      if (ctl.search) begin
        searching <= 1'b1;
        wd        <= '0;
        stat.done <= 1'b0;
      end else if (searching) begin
        if (word != '0) begin
          searching  <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b1;
          found_idx  <= NIDX_W'({wd, enc});
        end else if (wd == WD_W'(WORDS - 1)) begin
          searching  <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b0;
        end else begin
          wd        <= wd + 1'b1;
          stat.done <= 1'b0;
        end
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

endmodule

[src/chained_hash_table.sv]
// Top level of the chained hash table: request sequencer, head and node memories.
// Depends on chash_pkg, chash_ram and chash_free_map.
//
// Key to handle store with separate chaining. The bucket is the low bits of the
// key (BUCKET_COUNT is a power of two); each bucket has a head slot and further
// entries come from a shared node pool, lowest free node first. After reset a
// clearing pass empties the head slots; no request is taken meanwhile. A
// request settled at the head slot passes S_HEAD and S_DONE, where its result is
// registered onto the output once the output is free; the sequencer then returns
// to S_IDLE for the next request. Each chain node visited adds a pass through
// S_NODE, since each node costs one read of the node memory. An insert that
// needs a node waits in S_ALLOC for the free-node search, which scans 32 pool
// entries per cycle. One request is in work at a time; a new one is taken while
// the previous result still waits on the output.
module chained_hash_table #(
  parameter int BUCKET_COUNT = 64,
  parameter int POOL_NODES   = 64,
  parameter int KEY_BITS     = 22,
  parameter int HANDLE_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // key, value from bit 0 up, zero padded to whole bytes
  input  logic [((KEY_BITS + HANDLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // kind
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status, found_value, element_count from bit 0 up, zero padded to whole bytes
  output logic [((2 + HANDLE_BITS + 8 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import chash_pkg::*;

  localparam int BKT_W  = BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1;
  localparam int NIDX_W = POOL_NODES > 1 ? $clog2(POOL_NODES) : 1;
  localparam int LINK_W = $clog2(POOL_NODES + 1);
  localparam int CNT_W  = $clog2(BUCKET_COUNT + POOL_NODES + 1);
  localparam int ENT_W  = KEY_BITS + HANDLE_BITS + LINK_W;
  localparam int OUT_W  = ((2 + HANDLE_BITS + 8 + 7) / 8) * 8;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_NODE  = 3'd4;
  localparam logic [2:0] S_PULL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             state, state_next;
  logic [BKT_W-1:0]       clr_addr, clr_addr_next;
  logic [1:0]             op_kind, op_kind_next;
  logic [KEY_BITS-1:0]    op_key, op_key_next;
  logic [HANDLE_BITS-1:0] op_val, op_val_next;
  logic [BKT_W-1:0]       bkt, bkt_next;
  logic [LINK_W-1:0]      cur, cur_next;
  logic                   prev_head, prev_head_next;
  logic [NIDX_W-1:0]      prev_idx, prev_idx_next;
  logic [KEY_BITS-1:0]    prev_key, prev_key_next;
  logic [HANDLE_BITS-1:0] prev_val, prev_val_next;
  logic [LINK_W-1:0]      new_link, new_link_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [1:0]             res_status, res_status_next;
  logic [HANDLE_BITS-1:0] res_found, res_found_next;

  logic                   s_acc, load_out;
  logic [KEY_BITS-1:0]    in_key;
  logic [HANDLE_BITS-1:0] in_val;

  logic                   hwe, nwe;
  logic [BKT_W-1:0]       hwaddr, hraddr;
  logic [NIDX_W-1:0]      nwaddr, nraddr;
  logic [ENT_W-1:0]       hwdata, hrdata, nwdata, nrdata;

  logic [KEY_BITS-1:0]    hd_key, nd_key;
  logic [HANDLE_BITS-1:0] hd_val, nd_val;
  logic [LINK_W-1:0]      hd_next, nd_next;

  fm_ctl_t                fm_ctl;
  fm_stat_t               fm_stat;
  logic [NIDX_W-1:0]      fm_found, fm_take, fm_give;

  assign in_key = s_axis_tdata[KEY_BITS-1:0];
  assign in_val = s_axis_tdata[KEY_BITS +: HANDLE_BITS];
  assign s_axis_tready = (state == S_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign load_out = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign hd_next = hrdata[LINK_W-1:0];
  assign hd_val  = hrdata[LINK_W +: HANDLE_BITS];
  assign hd_key  = hrdata[LINK_W + HANDLE_BITS +: KEY_BITS];
  assign nd_next = nrdata[LINK_W-1:0];
  assign nd_val  = nrdata[LINK_W +: HANDLE_BITS];
  assign nd_key  = nrdata[LINK_W + HANDLE_BITS +: KEY_BITS];

  assign hraddr = (state == S_IDLE) ? BKT_W'(in_key) : bkt;
  assign nraddr = NIDX_W'(cur_next - LINK_W'(1));

  chash_ram #(.WIDTH(ENT_W), .DEPTH(BUCKET_COUNT)) u_head (
    .clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata),
    .raddr(hraddr), .rdata(hrdata)
  );

  chash_ram #(.WIDTH(ENT_W), .DEPTH(POOL_NODES)) u_node (
    .clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata),
    .raddr(nraddr), .rdata(nrdata)
  );

  chash_free_map #(.POOL_NODES(POOL_NODES)) u_free (
    .clk(clk), .rst(rst), .ctl(fm_ctl), .take_idx(fm_take), .give_idx(fm_give),
    .stat(fm_stat), .found_idx(fm_found)
  );

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    op_kind_next    = op_kind;
    op_key_next     = op_key;
    op_val_next     = op_val;
    bkt_next        = bkt;
    cur_next        = cur;
    prev_head_next  = prev_head;
    prev_idx_next   = prev_idx;
    prev_key_next   = prev_key;
    prev_val_next   = prev_val;
    new_link_next   = new_link;
    count_next      = count;
    res_status_next = res_status;
    res_found_next  = res_found;
    hwe    = 1'b0;
    hwaddr = bkt;
    hwdata = hrdata;
    nwe    = 1'b0;
    nwaddr = NIDX_W'(cur - LINK_W'(1));
    nwdata = nrdata;
    fm_ctl  = '0;
    fm_take = fm_found;
    fm_give = NIDX_W'(cur - LINK_W'(1));

    unique case (state)
      S_CLR: begin
        hwe    = 1'b1;
        hwaddr = clr_addr;
        hwdata = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == BKT_W'(BUCKET_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          op_kind_next    = s_axis_tuser;
          op_key_next     = in_key;
          op_val_next     = in_val;
          bkt_next        = BKT_W'(in_key);
          res_status_next = ST_OK;
          res_found_next  = '0;
          if (s_axis_tuser == KIND_NOP) begin
            state_next = S_DONE;
          end else if (in_key == '0) begin
            res_status_next = ST_ZERO;
            state_next      = S_DONE;
          end else begin
            state_next = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cur_next       = hd_next;
        prev_head_next = 1'b1;
        prev_key_next  = hd_key;
        prev_val_next  = hd_val;
        state_next     = S_DONE;
        case (op_kind)
          KIND_INSERT: begin
            if (hd_key == '0) begin
              hwe        = 1'b1;
              hwdata     = {op_key, op_val, hd_next};
              count_next = count + CNT_W'(1);
            end else begin
              fm_ctl.search = 1'b1;
              state_next    = S_ALLOC;
            end
          end
          KIND_LOOKUP: begin
            if (hd_key == op_key) begin
              res_found_next = hd_val;
            end else if (hd_next == '0) begin
              res_status_next = ST_MISSING;
            end else begin
              state_next = S_NODE;
            end
          end
          default: begin
            if (hd_key == op_key) begin
              if (hd_next != '0) begin
                state_next = S_PULL;
              end else begin
                hwe    = 1'b1;
                hwdata = {{KEY_BITS{1'b0}}, hd_val, {LINK_W{1'b0}}};
                if (count != '0) count_next = count - CNT_W'(1);
              end
            end else if (hd_next == '0) begin
              res_status_next = ST_MISSING;
            end else begin
              state_next = S_NODE;
            end
          end
        endcase
      end
      S_ALLOC: begin
        if (fm_stat.done) begin
          state_next = S_DONE;
          if (!fm_stat.found) begin
            res_status_next = ST_FULL;
          end else begin
            // The new node is written now; it is off every chain until linked.
            fm_ctl.take   = 1'b1;
            nwe           = 1'b1;
            nwaddr        = fm_found;
            nwdata        = {op_key, op_val, {LINK_W{1'b0}}};
            new_link_next = LINK_W'(fm_found) + LINK_W'(1);
            count_next    = count + CNT_W'(1);
            if (cur == '0) begin
              hwe    = 1'b1;
              hwdata = {hd_key, hd_val, LINK_W'(fm_found) + LINK_W'(1)};
            end else begin
              state_next = S_NODE;
            end
          end
        end
      end
      S_NODE: begin
        state_next = S_DONE;
        case (op_kind)
          KIND_INSERT: begin
            if (nd_next == '0) begin
              nwe    = 1'b1;
              nwdata = {nd_key, nd_val, new_link};
            end else begin
              cur_next   = nd_next;
              state_next = S_NODE;
            end
          end
          KIND_LOOKUP: begin
            if (nd_key == op_key) begin
              res_found_next = nd_val;
            end else if (nd_next == '0) begin
              res_status_next = ST_MISSING;
            end else begin
              cur_next   = nd_next;
              state_next = S_NODE;
            end
          end
          default: begin
            if (nd_key == op_key) begin
              // Unlink: the predecessor takes over this node's successor.
              fm_ctl.give = 1'b1;
              if (prev_head) begin
                hwe    = 1'b1;
                hwdata = {prev_key, prev_val, nd_next};
              end else begin
                nwe    = 1'b1;
                nwaddr = prev_idx;
                nwdata = {prev_key, prev_val, nd_next};
              end
              if (count != '0) count_next = count - CNT_W'(1);
            end else if (nd_next == '0) begin
              res_status_next = ST_MISSING;
            end else begin
              prev_head_next = 1'b0;
              prev_idx_next  = NIDX_W'(cur - LINK_W'(1));
              prev_key_next  = nd_key;
              prev_val_next  = nd_val;
              cur_next       = nd_next;
              state_next     = S_NODE;
            end
          end
        endcase
      end
      S_PULL: begin
        // The first node moves into the head slot and goes back to the pool.
        hwe         = 1'b1;
        hwdata      = {nd_key, nd_val, nd_next};
        fm_ctl.give = 1'b1;
        if (count != '0) count_next = count - CNT_W'(1);
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      count         <= '0;
      cur           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      count         <= count_next;
      cur           <= cur_next;
      m_axis_tvalid <= load_out || (m_axis_tvalid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    op_kind    <= op_kind_next;
    op_key     <= op_key_next;
    op_val     <= op_val_next;
    bkt        <= bkt_next;
    prev_head  <= prev_head_next;
    prev_idx   <= prev_idx_next;
    prev_key   <= prev_key_next;
    prev_val   <= prev_val_next;
    new_link   <= new_link_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (load_out) begin
      m_axis_tdata <= OUT_W'({8'(count), res_found, res_status});
    end
  end

  a_walk_link: assert property (@(posedge clk) disable iff (rst)
    (state == S_NODE) |-> (cur != '0))
    else $error("chain walk reached a null link");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUCKET_COUNT + POOL_NODES))
    else $error("entry count above capacity");

  a_nop_fast: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tuser == KIND_NOP) |=> (state == S_DONE))
    else $error("no-op request did not finish at once");

  a_alloc_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC && fm_stat.done && fm_stat.found) |-> (op_kind == KIND_INSERT))
    else $error("node allocated outside an insert");

endmodule
